// ----- rtl/kbe_pkg.sv -----
// ---------------------------------------------------------------------------
// kbe_pkg: shared types and constants for the keyframe Bezier easing core
// Transaction structs, controller commands, state encoding and fixed constants.
// ---------------------------------------------------------------------------
package kbe_pkg;

    // Control point magnitude width and signed storage width.
    localparam int MW    = 39;
    localparam int PW    = 40;
    // Low chunk width of the split multiplier.
    localparam int CHUNK = 20;

    // ceil(2^32 / 100): exact floor(n / 100) for n below 2^23.
    localparam logic [25:0] RECIP_100   = 26'd42949673;
    localparam int          RECIP_SHIFT = 32;

    localparam logic [38:0] HANDLE_MAX  = 39'h40_0000_0000;
    localparam int          EASED_LIMIT = 524288;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DUR = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // Dividend width of the shared divider; also its step count.
    function automatic int kbe_div_width(input int f);
        return (33 + f > 54) ? 33 + f : 54;
    endfunction

    typedef struct packed {
        logic signed [31:0] prev_time;
        logic signed [31:0] prev_value_x;
        logic signed [31:0] prev_value_y;
        logic signed [31:0] prev_speed;
        logic [22:0]        prev_influence;
        logic signed [31:0] next_time;
        logic signed [31:0] next_value_x;
        logic signed [31:0] next_value_y;
        logic signed [31:0] next_speed;
        logic [22:0]        next_influence;
        logic [16:0]        progress;
    } kbe_in_t;

    typedef struct packed {
        logic signed [20:0] eased_fraction;
        logic [16:0]        curve_param;
        logic [1:0]         status;
    } kbe_out_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_PREP, OP_SQX, OP_SQY, OP_SQSUM, OP_SQRT_STEP,
        OP_AVG_INIT, OP_DIV_STEP, OP_AVG_DONE, OP_HY_INIT, OP_HY_DONE,
        OP_BIS_INIT, OP_MID, OP_EV_LOAD, OP_MUL_LO, OP_MUL_HI, OP_MUL_SUM,
        OP_TERM_ACC, OP_DECIDE, OP_FINAL_T, OP_FINISH
    } kbe_op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_SQX, S_SQY, S_SQSUM, S_SQRT, S_AVG_INIT, S_DIV_AVG,
        S_AVG_DONE, S_HY1_INIT, S_DIV_Y1, S_HY1_DONE, S_HY2_INIT, S_DIV_Y2,
        S_HY2_DONE, S_BIS_INIT, S_MID, S_EV_LOAD, S_MUL_LO, S_MUL_HI,
        S_MUL_SUM, S_TERM_ACC, S_DECIDE, S_FINAL_T, S_FINISH
    } kbe_state_t;

    typedef struct packed {
        kbe_op_t    op;
        logic [1:0] term;
        logic       use_t;
        logic       curve_y;
        logic       sel;
    } kbe_cmd_t;

    typedef struct packed {
        logic dur_zero;
        logic hit;
    } kbe_stat_t;

endpackage

// ----- rtl/keyframe_bezier_easing_core.sv -----
// ---------------------------------------------------------------------------
// keyframe_bezier_easing_core: keyframe easing by a cubic Bezier timing curve
// Finds the curve parameter for a progress fraction by bisection and returns
// the eased value fraction.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake                   Payload     Transaction
//   item      item_valid / item_ready     kbe_in_t    two keyframes, progress
//   result    result_valid / result_ready kbe_out_t   eased fraction, t, status
//
// One item is processed at a time. The divider width is 54 for 16 fraction
// bits. The one-bit-per-cycle divider, the 32-step root and the split
// multiplier in each Bezier evaluation set the length of a transaction.
// A zero duration skips the arithmetic and goes straight to finish. The
// finished result sits in its own register, so a new item is accepted
// while the previous result still waits on result_ready.
// Reset is asynchronous and active low and returns the sequencer to idle.
//
module keyframe_bezier_easing_core #(
    parameter int FRACTION_BITS = 16,
    parameter int BISECT_STEPS  = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  kbe_pkg::kbe_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output kbe_pkg::kbe_out_t result
);
    import kbe_pkg::*;

    // The divider runs one quotient bit per cycle over the full dividend.
    localparam int DIV_STEPS = kbe_div_width(FRACTION_BITS);

    kbe_cmd_t  cmd;
    kbe_stat_t stat;

    // The controller owns every counter and the result handshake; the
    // datapath only reacts to the command issued in each cycle.
    kbe_controller #(
        .DIV_STEPS    (DIV_STEPS),
        .BISECT_STEPS (BISECT_STEPS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // The datapath holds the captured transaction, the mean speed, the four
    // control points, the bisection bounds and the result register.
    kbe_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk    (clk),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

// ----- rtl/kbe_datapath.sv -----
// ---------------------------------------------------------------------------
// kbe_datapath: arithmetic of the easing core
// Root, shared divider, split multiplier, bisection bounds and result register.
// ---------------------------------------------------------------------------
module kbe_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  logic             clk,
    input  kbe_pkg::kbe_in_t item,
    input  kbe_pkg::kbe_cmd_t cmd,
    output kbe_pkg::kbe_stat_t stat,
    output kbe_pkg::kbe_out_t result
);
    import kbe_pkg::*;

    localparam int F       = FRACTION_BITS;
    localparam int TW      = F + 1;
    localparam int DVW     = kbe_div_width(F);
    localparam int DSW     = DVW + 7;
    localparam int HIW     = MW - CHUNK;
    localparam int AW      = MW + 5;
    localparam int EPS_RAW = ((1 << F) + 5000) / 10000;
    localparam int EPS     = (EPS_RAW == 0) ? 1 : EPS_RAW;
    localparam logic [TW-1:0] ONE = TW'(1) << F;
    localparam logic signed [AW-1:0] EMAX = AW'(EASED_LIMIT);
    localparam logic signed [AW-1:0] EMIN = -EMAX;

    kbe_in_t                item_reg;
    logic                   dur_zero_reg, shift_reg;
    logic [32:0]            durmag_reg;
    logic [31:0]            adx_reg, ady_reg;
    logic [63:0]            prod_reg, sq_reg;
    logic [31:0]            root_reg;
    logic [33:0]            srem_reg;
    logic [DVW-1:0]         num_reg, avg_reg;
    logic [DSW-1:0]         den_reg;
    logic [DSW:0]           drem_reg;
    logic signed [PW-1:0]   x1_reg, x2_reg, y1_reg, y2_reg;
    logic [TW-1:0]          l_reg, r_reg, t_reg, ep_reg;
    logic                   lneg_reg, lzero_reg, rneg_reg, rzero_reg, found_reg;
    logic [MW-1:0]          m_reg;
    logic                   tneg_reg;
    logic [CHUNK+TW-1:0]    plo_reg;
    logic [HIW+TW-1:0]      phi_reg;
    logic signed [AW-1:0]   acc_reg;
    kbe_out_t               result_reg;

    logic signed [32:0]     dur_w, dx_w, dy_w, sp_ext_w, sp_mag33_w;
    logic [32:0]            durmag_w, adx_w, ady_w;
    logic                   shift_w;
    logic [48:0]            x1prod_w, x2prod_w;
    logic signed [PW-1:0]   x2_w;
    logic [35:0]            rtrial_w, rcand_w, rdiff_w;
    logic                   rge_w;
    logic [DSW:0]           dsh_w, ddiff_w;
    logic                   dge_w;
    logic [32:0]            dist_w;
    logic signed [31:0]     sp_w;
    logic [22:0]            inf_w;
    logic [54:0]            hprod_w;
    logic [DSW-1:0]         avg100_w;
    logic [MW-1:0]          hq_w;
    logic signed [PW-1:0]   hv_w, p_w, pmag_w;
    logic [TW:0]            sum_lr_w;
    logic [TW-1:0]          mid_w, u_w, bsel_w, tfin_w;
    logic [MW+TW-1:0]       full_w;
    logic [AW-1:0]          tv_w;
    logic signed [AW-1:0]   xs_w, mx_w, rx_w;
    logic                   mzero_w, mneg_w;
    logic [TW+16:0]         t_ext_w;

    always_comb
    begin
        dur_w    = $signed({item_reg.next_time[31], item_reg.next_time})
                 - $signed({item_reg.prev_time[31], item_reg.prev_time});
        dx_w     = $signed({item_reg.next_value_x[31], item_reg.next_value_x})
                 - $signed({item_reg.prev_value_x[31], item_reg.prev_value_x});
        dy_w     = $signed({item_reg.next_value_y[31], item_reg.next_value_y})
                 - $signed({item_reg.prev_value_y[31], item_reg.prev_value_y});
        durmag_w = dur_w[32] ? 33'(-dur_w) : 33'(dur_w);
        adx_w    = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
        ady_w    = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
        shift_w  = adx_w[32] | adx_w[31] | ady_w[32] | ady_w[31];

        x1prod_w = 49'(item_reg.prev_influence) * 49'(RECIP_100);
        x2prod_w = 49'(item_reg.next_influence) * 49'(RECIP_100);
        x2_w     = $signed(PW'(ONE)) - $signed(PW'(x2prod_w[48:RECIP_SHIFT]));

        // One radicand digit pair per step.
        rtrial_w = {srem_reg, sq_reg[63:62]};
        rcand_w  = {2'b00, root_reg, 2'b01};
        rge_w    = rtrial_w >= rcand_w;
        rdiff_w  = rtrial_w - rcand_w;

        // Restoring divider, one quotient bit per step.
        dsh_w    = {drem_reg[DSW-1:0], num_reg[DVW-1]};
        dge_w    = dsh_w >= {1'b0, den_reg};
        ddiff_w  = dsh_w - {1'b0, den_reg};

        dist_w   = shift_reg ? {root_reg, 1'b0} : {1'b0, root_reg};

        sp_w       = cmd.sel ? item_reg.next_speed : item_reg.prev_speed;
        inf_w      = cmd.sel ? item_reg.next_influence : item_reg.prev_influence;
        sp_ext_w   = $signed({sp_w[31], sp_w});
        sp_mag33_w = sp_w[31] ? -sp_ext_w : sp_ext_w;
        hprod_w    = 55'(sp_mag33_w[31:0]) * 55'(inf_w);
        avg100_w   = (DSW'(avg_reg) << 6) + (DSW'(avg_reg) << 5) + (DSW'(avg_reg) << 2);
        hq_w       = (num_reg > DVW'(HANDLE_MAX)) ? HANDLE_MAX : num_reg[MW-1:0];
        hv_w       = sp_w[31] ? -$signed(PW'(hq_w)) : $signed(PW'(hq_w));

        sum_lr_w = {1'b0, l_reg} + {1'b0, r_reg};
        mid_w    = sum_lr_w[TW:1];
        tfin_w   = found_reg ? t_reg : mid_w;
        u_w      = ONE - ep_reg;
        bsel_w   = cmd.use_t ? ep_reg : u_w;

        case (cmd.term)
            2'd0:    p_w = cmd.curve_y ? y1_reg : x1_reg;
            2'd1:    p_w = cmd.curve_y ? y2_reg : x2_reg;
            default: p_w = $signed(PW'(ep_reg));
        endcase
        pmag_w = p_w[PW-1] ? -p_w : p_w;

        full_w = (MW+TW)'(plo_reg) + ((MW+TW)'(phi_reg) << CHUNK);
        tv_w   = (cmd.term == 2'd2) ? AW'(m_reg) : (AW'(m_reg) << 1) + AW'(m_reg);

        xs_w    = $signed(AW'(item_reg.progress));
        mx_w    = acc_reg - xs_w;
        rx_w    = $signed(AW'(ONE)) - xs_w;
        mzero_w = mx_w == '0;
        mneg_w  = mx_w[AW-1];

        t_ext_w = {17'b0, t_reg};

        stat.dur_zero = dur_zero_reg;
        stat.hit      = mzero_w | lzero_reg | rzero_reg;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                item_reg <= item;
            end
            OP_PREP:
            begin
                dur_zero_reg <= dur_w == '0;
                durmag_reg   <= durmag_w;
                shift_reg    <= shift_w;
                adx_reg      <= shift_w ? adx_w[32:1] : adx_w[31:0];
                ady_reg      <= shift_w ? ady_w[32:1] : ady_w[31:0];
                x1_reg       <= $signed(PW'(x1prod_w[48:RECIP_SHIFT]));
                x2_reg       <= x2_w;
            end
            OP_SQX:
            begin
                prod_reg <= 64'(adx_reg) * 64'(adx_reg);
            end
            OP_SQY:
            begin
                sq_reg   <= prod_reg;
                prod_reg <= 64'(ady_reg) * 64'(ady_reg);
            end
            OP_SQSUM:
            begin
                sq_reg   <= sq_reg + prod_reg;
                root_reg <= '0;
                srem_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                srem_reg <= rge_w ? rdiff_w[33:0] : rtrial_w[33:0];
                root_reg <= {root_reg[30:0], rge_w};
                sq_reg   <= {sq_reg[61:0], 2'b00};
            end
            OP_AVG_INIT:
            begin
                num_reg  <= DVW'(dist_w) << F;
                den_reg  <= DSW'(durmag_reg);
                drem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                drem_reg <= dge_w ? ddiff_w : dsh_w;
                num_reg  <= {num_reg[DVW-2:0], dge_w};
            end
            OP_AVG_DONE:
            begin
                avg_reg <= (num_reg == '0) ? DVW'(EPS) : num_reg;
            end
            OP_HY_INIT:
            begin
                num_reg  <= DVW'(hprod_w);
                den_reg  <= avg100_w;
                drem_reg <= '0;
            end
            OP_HY_DONE:
            begin
                if (cmd.sel)
                begin
                    y2_reg <= $signed(PW'(ONE)) - hv_w;
                end
                else
                begin
                    y1_reg <= hv_w;
                end
            end
            OP_BIS_INIT:
            begin
                l_reg     <= '0;
                r_reg     <= ONE;
                found_reg <= 1'b0;
                lzero_reg <= xs_w == '0;
                lneg_reg  <= xs_w != '0;
                rzero_reg <= rx_w == '0;
                rneg_reg  <= rx_w[AW-1];
            end
            OP_MID:
            begin
                ep_reg  <= mid_w;
                acc_reg <= '0;
            end
            OP_EV_LOAD:
            begin
                m_reg    <= pmag_w[MW-1:0];
                tneg_reg <= p_w[PW-1];
            end
            OP_MUL_LO:
            begin
                plo_reg <= (CHUNK+TW)'(m_reg[CHUNK-1:0]) * (CHUNK+TW)'(bsel_w);
            end
            OP_MUL_HI:
            begin
                phi_reg <= (HIW+TW)'(m_reg[MW-1:CHUNK]) * (HIW+TW)'(bsel_w);
            end
            OP_MUL_SUM:
            begin
                m_reg <= full_w[F +: MW];
            end
            OP_TERM_ACC:
            begin
                acc_reg <= tneg_reg ? acc_reg - $signed(tv_w) : acc_reg + $signed(tv_w);
            end
            OP_DECIDE:
            begin
                if (mzero_w)
                begin
                    t_reg     <= ep_reg;
                    found_reg <= 1'b1;
                end
                else if (lzero_reg)
                begin
                    t_reg     <= l_reg;
                    found_reg <= 1'b1;
                end
                else if (rzero_reg)
                begin
                    t_reg     <= r_reg;
                    found_reg <= 1'b1;
                end
                else if (lneg_reg != mneg_w)
                begin
                    r_reg     <= ep_reg;
                    rneg_reg  <= mneg_w;
                    rzero_reg <= 1'b0;
                end
                else if (rneg_reg != mneg_w)
                begin
                    l_reg     <= ep_reg;
                    lneg_reg  <= mneg_w;
                    lzero_reg <= 1'b0;
                end
            end
            OP_FINAL_T:
            begin
                t_reg   <= tfin_w;
                ep_reg  <= tfin_w;
                acc_reg <= '0;
            end
            OP_FINISH:
            begin
                if (dur_zero_reg)
                begin
                    result_reg.eased_fraction <= '0;
                    result_reg.curve_param    <= '0;
                    result_reg.status         <= ST_ZERO_DUR;
                end
                else
                begin
                    result_reg.curve_param <= t_ext_w[16:0];
                    if (acc_reg > EMAX)
                    begin
                        result_reg.eased_fraction <= EMAX[20:0];
                        result_reg.status         <= ST_SAT;
                    end
                    else if (acc_reg < EMIN)
                    begin
                        result_reg.eased_fraction <= EMIN[20:0];
                        result_reg.status         <= ST_SAT;
                    end
                    else
                    begin
                        result_reg.eased_fraction <= acc_reg[20:0];
                        result_reg.status         <= ST_OK;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result = result_reg;

endmodule

// ----- rtl/kbe_controller.sv -----
// ---------------------------------------------------------------------------
// kbe_controller: sequencer of the easing core
// Steps the datapath through root, divisions, bisection and final evaluation.
// ---------------------------------------------------------------------------
module kbe_controller #(
    parameter int DIV_STEPS    = 54,
    parameter int BISECT_STEPS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    input  kbe_pkg::kbe_stat_t stat,
    output kbe_pkg::kbe_cmd_t  cmd
);
    import kbe_pkg::*;

    localparam int CW = $clog2(DIV_STEPS);
    localparam int SW = $clog2(BISECT_STEPS);

    kbe_state_t     state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [SW-1:0]  step_reg, step_next;
    logic [1:0]     term_reg, term_next, midx_reg, midx_next;
    logic           curve_y_reg, curve_y_next;
    logic           res_valid_reg, res_valid_next;
    logic           last_mul;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            term_reg      <= '0;
            midx_reg      <= '0;
            curve_y_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            term_reg      <= term_next;
            midx_reg      <= midx_next;
            curve_y_reg   <= curve_y_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        term_next      = term_reg;
        midx_next      = midx_reg;
        curve_y_next   = curve_y_reg;
        res_valid_next = res_valid_reg && !result_ready;

        cmd.op      = OP_NONE;
        cmd.term    = term_reg;
        cmd.curve_y = curve_y_reg;
        cmd.sel     = 1'b0;
        case (term_reg)
            2'd0:    cmd.use_t = midx_reg == 2'd2;
            2'd1:    cmd.use_t = midx_reg != 2'd0;
            default: cmd.use_t = 1'b1;
        endcase
        last_mul = (term_reg == 2'd2) ? (midx_reg == 2'd1) : (midx_reg == 2'd2);

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                if (stat.dur_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_SQX;
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                cmd.op     = OP_SQY;
                state_next = S_SQSUM;
            end
            S_SQSUM:
            begin
                cmd.op     = OP_SQSUM;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(31))
                begin
                    state_next = S_AVG_INIT;
                end
            end
            S_AVG_INIT:
            begin
                cmd.op     = OP_AVG_INIT;
                cnt_next   = '0;
                state_next = S_DIV_AVG;
            end
            S_DIV_AVG, S_DIV_Y1, S_DIV_Y2:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    case (state_reg)
                        S_DIV_AVG: state_next = S_AVG_DONE;
                        S_DIV_Y1:  state_next = S_HY1_DONE;
                        default:   state_next = S_HY2_DONE;
                    endcase
                end
            end
            S_AVG_DONE:
            begin
                cmd.op     = OP_AVG_DONE;
                state_next = S_HY1_INIT;
            end
            S_HY1_INIT:
            begin
                cmd.op     = OP_HY_INIT;
                cnt_next   = '0;
                state_next = S_DIV_Y1;
            end
            S_HY1_DONE:
            begin
                cmd.op     = OP_HY_DONE;
                state_next = S_HY2_INIT;
            end
            S_HY2_INIT:
            begin
                cmd.op     = OP_HY_INIT;
                cmd.sel    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV_Y2;
            end
            S_HY2_DONE:
            begin
                cmd.op     = OP_HY_DONE;
                cmd.sel    = 1'b1;
                state_next = S_BIS_INIT;
            end
            S_BIS_INIT:
            begin
                cmd.op       = OP_BIS_INIT;
                step_next    = '0;
                curve_y_next = 1'b0;
                state_next   = S_MID;
            end
            S_MID:
            begin
                cmd.op     = OP_MID;
                term_next  = '0;
                state_next = S_EV_LOAD;
            end
            S_EV_LOAD:
            begin
                cmd.op     = OP_EV_LOAD;
                midx_next  = '0;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = S_MUL_SUM;
            end
            S_MUL_SUM:
            begin
                cmd.op = OP_MUL_SUM;
                if (last_mul)
                begin
                    state_next = S_TERM_ACC;
                end
                else
                begin
                    midx_next  = midx_reg + 1'b1;
                    state_next = S_MUL_LO;
                end
            end
            S_TERM_ACC:
            begin
                cmd.op = OP_TERM_ACC;
                if (term_reg == 2'd2)
                begin
                    state_next = curve_y_reg ? S_FINISH : S_DECIDE;
                end
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = S_EV_LOAD;
                end
            end
            S_DECIDE:
            begin
                cmd.op = OP_DECIDE;
                if (stat.hit || step_reg == SW'(BISECT_STEPS - 1))
                begin
                    state_next = S_FINAL_T;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_MID;
                end
            end
            S_FINAL_T:
            begin
                cmd.op       = OP_FINAL_T;
                curve_y_next = 1'b1;
                term_next    = '0;
                state_next   = S_EV_LOAD;
            end
            S_FINISH:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    cmd.op         = OP_FINISH;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_ready   = state_reg == S_IDLE;
    assign result_valid = res_valid_reg;

endmodule

// ----- tb/sv/keyframe_bezier_easing_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyframe_bezier_easing_core_tb: self-checking bench for the easing core
// Drives keyframe pairs through the item channel. Results are compared field
// by field against a fixed-point easing predictor, in order. A directed table
// comes first, then random traffic in phases with different idle patterns.
// ---------------------------------------------------------------------------
module keyframe_bezier_easing_core_tb;
    import kbe_pkg::*;

    localparam int     FB       = 16;
    localparam int     STEPS    = 10;
    localparam longint ONE      = 64'sd1 <<< FB;
    localparam longint EASE_MAX = 64'sd524288;
    localparam longint Y_LIMIT  = 64'sd1 <<< 38;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_ready;
    kbe_in_t  item;
    logic     result_valid;
    logic     result_ready;
    kbe_out_t result;

    // Expected results in order of acceptance.
    kbe_out_t pending_results[$];
    int       error_count;
    // Percent chance of idling per cycle on each side.
    int       send_idle_pct;
    int       recv_stall_pct;
    // Remaining cycles of a forced long receiver hold-off.
    int       recv_hold_cycles;

    typedef struct {
        kbe_in_t  stim;
        bit       known;
        kbe_out_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    keyframe_bezier_easing_core #(
        .FRACTION_BITS(FB),
        .BISECT_STEPS (STEPS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    // The clock runs at a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // -----------------------------------------------------------------------
    // Fixed-point easing predictor.
    // -----------------------------------------------------------------------

    function automatic longint unsigned abs64(input longint a);
        return (a < 0) ? 64'd0 - longint'(a) : longint'(a);
    endfunction

    // Product by a nonnegative fraction, truncated toward zero.
    function automatic longint fx_mul(input longint a, input longint b);
        longint unsigned r;
        r = (abs64(a) * longint'(b)) >> FB;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitpos;
        root   = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 0)
        begin
            if (v >= root + bitpos)
            begin
                v    = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end
            else
                root = root >> 1;
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // Cubic Bezier from 0 to ONE with inner points p1 and p2.
    function automatic longint bezier_at(input longint p1, input longint p2, input longint t);
        longint u;
        u = ONE - t;
        return fx_mul(fx_mul(fx_mul(p1, u), u), t) * 3
             + fx_mul(fx_mul(fx_mul(p2, u), t), t) * 3
             + fx_mul(fx_mul(t, t), t);
    endfunction

    function automatic longint handle_height(input longint speed, input longint unsigned infl,
                                             input longint unsigned avg);
        longint unsigned q;
        q = ((abs64(speed) * infl) / 100) / avg;
        if (q > longint'(Y_LIMIT))
            q = Y_LIMIT;
        return (speed < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic kbe_out_t predict_easing(input kbe_in_t x);
        kbe_out_t        o;
        longint          dur;
        longint unsigned adx;
        longint unsigned ady;
        longint unsigned dist_len;
        longint unsigned avg;
        int              sh;
        longint          x1, x2, y1, y2, lo, hi, t, res, mid, lx, mx, rx, prog;
        bit              found;
        logic [1:0]      st;
        dur = longint'(x.next_time) - longint'(x.prev_time);
        if (dur == 0)
        begin
            o.eased_fraction = '0;
            o.curve_param    = '0;
            o.status         = ST_ZERO_DUR;
            return o;
        end
        adx = abs64(longint'(x.next_value_x) - longint'(x.prev_value_x));
        ady = abs64(longint'(x.next_value_y) - longint'(x.prev_value_y));
        sh  = (adx >= (64'd1 << 31) || ady >= (64'd1 << 31)) ? 1 : 0;
        adx = adx >> sh;
        ady = ady >> sh;
        dist_len = int_sqrt(adx * adx + ady * ady) << sh;
        avg      = (dist_len << FB) / abs64(dur);
        // A standstill falls back to a tiny speed so the handles stay finite.
        if (avg == 0)
        begin
            avg = (longint'(ONE) + 5000) / 10000;
            if (avg == 0)
                avg = 1;
        end
        x1 = longint'(x.prev_influence) / 100;
        x2 = ONE - longint'(x.next_influence) / 100;
        y1 = handle_height(longint'(x.prev_speed), x.prev_influence, avg);
        y2 = ONE - handle_height(longint'(x.next_speed), x.next_influence, avg);
        prog  = longint'(x.progress);
        lo    = 0;
        hi    = ONE;
        t     = 0;
        found = 0;
        for (int i = 0; i < STEPS && !found; i++)
        begin
            mid = (lo + hi) >>> 1;
            lx  = bezier_at(x1, x2, lo) - prog;
            mx  = bezier_at(x1, x2, mid) - prog;
            rx  = bezier_at(x1, x2, hi) - prog;
            if (mx == 0)
            begin
                t = mid;
                found = 1;
            end
            else if (lx == 0)
            begin
                t = lo;
                found = 1;
            end
            else if (rx == 0)
            begin
                t = hi;
                found = 1;
            end
            else if ((lx < 0) != (mx < 0))
                hi = mid;
            else if ((rx < 0) != (mx < 0))
                lo = mid;
        end
        if (!found)
            t = (lo + hi) >>> 1;
        res = bezier_at(y1, y2, t);
        st  = ST_OK;
        if (res > EASE_MAX)
        begin
            res = EASE_MAX;
            st  = ST_SAT;
        end
        if (res < -EASE_MAX)
        begin
            res = -EASE_MAX;
            st  = ST_SAT;
        end
        o.eased_fraction = res[20:0];
        o.curve_param    = t[16:0];
        o.status         = st;
        return o;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers.
    // -----------------------------------------------------------------------

    function automatic kbe_in_t make_item(input logic [31:0] pt, input logic [31:0] px,
                                          input logic [31:0] py, input logic [31:0] ps,
                                          input logic [22:0] pi, input logic [31:0] nt,
                                          input logic [31:0] nx, input logic [31:0] ny,
                                          input logic [31:0] ns, input logic [22:0] ni,
                                          input logic [16:0] prog);
        kbe_in_t x;
        x.prev_time      = pt;
        x.prev_value_x   = px;
        x.prev_value_y   = py;
        x.prev_speed     = ps;
        x.prev_influence = pi;
        x.next_time      = nt;
        x.next_value_x   = nx;
        x.next_value_y   = ny;
        x.next_speed     = ns;
        x.next_influence = ni;
        x.progress       = prog;
        return x;
    endfunction

    // A value whose magnitude spans many octaves.
    function automatic logic [31:0] spread_value();
        logic [31:0] v;
        v = $urandom >> $urandom_range(31, 0);
        return ($urandom_range(1, 0) != 0) ? -v : v;
    endfunction

    function automatic kbe_in_t random_item();
        kbe_in_t     x;
        int          pick;
        logic [31:0] dur;
        pick = $urandom_range(99, 0);
        x = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom);
        if (pick < 12)
            return x;  // raw noise over every bit of every field
        if (pick < 17)
        begin
            x.next_time = x.prev_time;
            return x;
        end
        // Plausible keyframes: short durations, percent influences, progress mostly in range.
        dur = $urandom_range(1 << 20, 1);
        x.prev_time      = $urandom_range(1 << 24, 0);
        x.next_time      = ($urandom_range(3, 0) == 0) ? x.prev_time - dur : x.prev_time + dur;
        x.prev_value_x   = spread_value();
        x.prev_value_y   = spread_value();
        x.next_value_x   = spread_value();
        x.next_value_y   = spread_value();
        x.prev_speed     = spread_value();
        x.next_speed     = spread_value();
        x.prev_influence = $urandom_range(6553600, 0);
        x.next_influence = $urandom_range(6553600, 0);
        x.progress       = ($urandom_range(19, 0) == 0) ? $urandom : $urandom_range(65536, 0);
        return x;
    endfunction

    // Offer one transaction and record its expectation when it is accepted.
    task automatic send_item(input kbe_in_t x, input kbe_out_t want);
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct)
                @(posedge clk);
        end
        item       <= x;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        pending_results.push_back(want);
    endtask

    task automatic send_random(input int count);
        kbe_in_t x;
        for (int n = 0; n < count; n++)
        begin
            x = random_item();
            send_item(x, predict_easing(x));
        end
    endtask

    // The sender stops until every outstanding transaction has come back.
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // -----------------------------------------------------------------------
    // Result checker and receiver back-pressure.
    // -----------------------------------------------------------------------
    initial
    begin
        kbe_out_t want;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (result.eased_fraction !== want.eased_fraction)
                        report_mismatch("eased_fraction", result.eased_fraction,
                                        want.eased_fraction);
                    if (result.curve_param !== want.curve_param)
                        report_mismatch("curve_param", result.curve_param, want.curve_param);
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                end
            end
            if (recv_hold_cycles > 0)
            begin
                recv_hold_cycles--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence.
    // -----------------------------------------------------------------------
    initial
    begin
        kbe_out_t zero_dur;
        kbe_out_t want;
        dir_row_t row;
        error_count      = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;

        zero_dur.eased_fraction = '0;
        zero_dur.curve_param    = '0;
        zero_dur.status         = ST_ZERO_DUR;

        // Zero duration rows, including the all-zero item right after reset.
        row.known = 1;
        row.want  = zero_dur;
        row.stim  = '0;
        dir_rows.push_back(row);
        row.stim = make_item(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                             23'h7f_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                             32'h7fff_ffff, 23'h7f_ffff, 17'h1_ffff);
        dir_rows.push_back(row);
        row.stim = make_item(32'h7fff_ffff, 0, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0, 17'd65536);
        dir_rows.push_back(row);

        row.known = 0;
        // Linear ease: no influence, standstill values.
        dir_rows.push_back('{make_item(0, 0, 0, 0, 0, 32'h1_0000, 0, 0, 0, 0, 17'd0), 0, '0});
        dir_rows.push_back('{make_item(0, 0, 0, 0, 0, 32'h1_0000, 0, 0, 0, 0, 17'd32768), 0, '0});
        dir_rows.push_back('{make_item(0, 0, 0, 0, 0, 32'h1_0000, 0, 0, 0, 0, 17'd65536), 0, '0});
        // Progress above one and at its field maximum: no sign change.
        dir_rows.push_back('{make_item(0, 0, 0, 0, 0, 32'h1_0000, 0, 0, 0, 0, 17'd65537), 0, '0});
        dir_rows.push_back('{make_item(0, 0, 0, 0, 0, 32'h1_0000, 0, 0, 0, 0, 17'h1_ffff), 0, '0});
        // Extreme times and values force the halved-root path.
        dir_rows.push_back('{make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1_0000,
                                       23'd2184533, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                       32'h1_0000, 23'd2184533, 17'd20000), 0, '0});
        dir_rows.push_back('{make_item(32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h8000_0000,
                                       23'd6553600, 32'h8000_0000, 32'h8000_0000, 0,
                                       32'h8000_0000, 23'd6553600, 17'd40000), 0, '0});
        // Huge speeds at a standstill: clamped handles and a saturated result.
        dir_rows.push_back('{make_item(0, 0, 0, 32'h7fff_ffff, 23'h7f_ffff, 32'h1, 0, 0,
                                       32'h7fff_ffff, 23'h7f_ffff, 17'd30000), 0, '0});
        dir_rows.push_back('{make_item(0, 0, 0, 32'h8000_0000, 23'd6553600, 32'h1, 0, 0,
                                       32'h8000_0000, 23'd6553600, 17'd50000), 0, '0});
        dir_rows.push_back('{make_item(0, 5, 7, 32'h7fff_ffff, 23'd3276800, 32'h10_0000, 9, 3,
                                       32'h8000_0000, 23'd3276800, 17'd10000), 0, '0});
        // Ordinary eases with mixed speeds.
        dir_rows.push_back('{make_item(32'h1_0000, 0, 0, 32'h2_0000, 23'd2184533, 32'h3_0000,
                                       32'h4_0000, 32'h3_0000, 32'h2_0000, 23'd2184533,
                                       17'd16384), 0, '0});
        dir_rows.push_back('{make_item(32'h3_0000, 32'h4_0000, 0, 32'hffff_0000, 23'd655360,
                                       32'h1_0000, 0, 32'h3_0000, 32'h5_0000, 23'd5898240,
                                       17'd49152), 0, '0});
        dir_rows.push_back('{make_item(0, 0, 0, 32'h1_0000, 23'd6553600, 32'h1_0000,
                                       32'h1_0000, 0, 32'h1_0000, 23'd0, 17'd1), 0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            want = dir_rows[k].known ? dir_rows[k].want : predict_easing(dir_rows[k].stim);
            send_item(dir_rows[k].stim, want);
        end
        drain();

        // Random traffic under each idling pattern.
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(250);
        send_idle_pct = 63; recv_stall_pct = 0;  send_random(250);
        send_idle_pct = 0;  recv_stall_pct = 63; send_random(250);
        send_idle_pct = 15; recv_stall_pct = 15; send_random(250);
        drain();

        // Long receiver hold-off with the sender still offering: the core fills up.
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 3000;
        send_random(50);
        drain();
        send_idle_pct = 15; recv_stall_pct = 15; send_random(100);

        drain();
        repeat (700) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
